>>> rtl/moc_pkg.sv
// shared types, widths and codes for the monomial order comparator
// no dependencies; imported by every module of the block

package moc_pkg;

	localparam int MAX_VARS  = 32;
	localparam int EXP_BITS  = 15;

	localparam int IDX_W     = $clog2(MAX_VARS + 2);
	localparam int DIFF_W    = EXP_BITS + 1;
	localparam int SUM_W     = DIFF_W + $clog2(MAX_VARS);
	localparam int REM_W     = SUM_W + 1;
	localparam int GS_W      = 6;
	localparam int MODE_W    = 2;
	localparam int CMP_W     = (IDX_W > GS_W) ? IDX_W : GS_W;

	localparam int S_DATA_W  = ((2 * EXP_BITS + 7) / 8) * 8;
	localparam int M_DATA_W  = 8;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;

	typedef logic signed [1:0] sgn_t;
	localparam sgn_t SGN_ZERO = 2'sd0;
	localparam sgn_t SGN_POS  = 2'sd1;
	localparam sgn_t SGN_NEG  = -2'sd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_LEX       = 2'd0,
		MODE_DEGLEX    = 2'd1,
		MODE_DEGREVLEX = 2'd2,
		MODE_BLOCK     = 2'd3
	} mode_t;

	localparam logic REG_ORDER_MODE = 1'b0;
	localparam logic REG_GROUP_SIZE = 1'b1;

	typedef struct packed {
		logic [EXP_BITS-1:0] exp_first;
		logic [EXP_BITS-1:0] exp_second;
		logic                last;
	} beat_t;

	typedef struct packed {
		mode_t            order_mode;
		logic [GS_W-1:0]  group_size;
	} cfg_t;

	typedef struct packed {
		logic valid;
		sgn_t order;
	} res_t;

endpackage

>>> rtl/moc_cfg.sv
// apb register file: order_mode and group_size
// depends on moc_pkg

module moc_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [moc_pkg::APB_AW-1:0] paddr,
	input  logic [moc_pkg::APB_DW-1:0] pwdata,
	output logic [moc_pkg::APB_DW-1:0] prdata,
	output logic                      pready,
	output moc_pkg::cfg_t             cfg
);
	import moc_pkg::*;

	mode_t           mode_q;
	logic [GS_W-1:0] group_size_q;
	logic            wr_en;
	logic            reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_LEX;
			group_size_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_ORDER_MODE: mode_q       <= mode_t'(pwdata[MODE_W-1:0]);
				REG_GROUP_SIZE: group_size_q <= pwdata[GS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_ORDER_MODE: prdata = APB_DW'(mode_q);
			REG_GROUP_SIZE: prdata = APB_DW'(group_size_q);
			default: ;
		endcase
	end

	assign cfg.order_mode = mode_q;
	assign cfg.group_size = group_size_q;

endmodule

>>> rtl/moc_in_stage.sv
// input register stage: holds one element beat until the accumulator takes it
// depends on moc_pkg

module moc_in_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [moc_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                        s_tlast,
	input  logic                        out_free,
	output logic                        take,
	output moc_pkg::beat_t              beat
);
	import moc_pkg::*;

	logic  valid_s1;
	beat_t beat_s1;

	assign take     = valid_s1 & (~beat_s1.last | out_free);
	assign s_tready = ~valid_s1 | take;
	assign beat     = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1.exp_first  <= s_tdata[EXP_BITS-1:0];
			beat_s1.exp_second <= s_tdata[2*EXP_BITS-1:EXP_BITS];
			beat_s1.last       <= s_tlast;
		end
	end

endmodule

>>> rtl/moc_accum.sv
// running difference and sign state, order decision on the last beat
// depends on moc_pkg

module moc_accum (
	input  logic           clk,
	input  logic           arst_n,
	input  moc_pkg::cfg_t  cfg,
	input  logic           take,
	input  moc_pkg::beat_t beat,
	output moc_pkg::res_t  res
);
	import moc_pkg::*;

	logic [IDX_W-1:0]         idx_q, idx_n;
	logic signed [DIFF_W-1:0] deg_q, deg_n;
	logic signed [SUM_W-1:0]  sum_q, sum_n;
	logic signed [REM_W-1:0]  rem_q, rem_n;
	sgn_t                     lex_first_q, lex_first_n;
	sgn_t                     all_last_q, all_last_n;
	sgn_t                     low_last_q, low_last_n;
	sgn_t                     high_last_q, high_last_n;

	logic signed [DIFF_W-1:0] diff;
	sgn_t                     s;
	logic                     is_deg, in_vars, in_low;
	sgn_t                     deg_s, sum_s, rem_s;
	sgn_t                     order;

	function automatic sgn_t sign_of(input logic signed [REM_W-1:0] v);
		sgn_t r;
		if (v == '0)
			r = SGN_ZERO;
		else if (v[REM_W-1])
			r = SGN_NEG;
		else
			r = SGN_POS;
		return r;
	endfunction

	always_comb begin
		diff    = $signed({1'b0, beat.exp_first}) - $signed({1'b0, beat.exp_second});
		s       = sign_of(REM_W'(diff));
		is_deg  = (idx_q == '0);
		in_vars = !is_deg && (idx_q <= IDX_W'(MAX_VARS));
		in_low  = in_vars && (CMP_W'(idx_q) <= CMP_W'(cfg.group_size));

		idx_n       = idx_q;
		deg_n       = deg_q;
		sum_n       = sum_q;
		rem_n       = rem_q;
		lex_first_n = lex_first_q;
		all_last_n  = all_last_q;
		low_last_n  = low_last_q;
		high_last_n = high_last_q;

		if (is_deg) begin
			deg_n = diff;
			rem_n = REM_W'(diff);
		end
		if (in_vars && s != SGN_ZERO) begin
			if (lex_first_q == SGN_ZERO)
				lex_first_n = s;
			all_last_n = s;
		end
		if (in_low) begin
			sum_n = sum_q + SUM_W'(diff);
			rem_n = rem_q - REM_W'(diff);
			if (s != SGN_ZERO)
				low_last_n = s;
		end else if (in_vars && s != SGN_ZERO) begin
			high_last_n = s;
		end
		if (is_deg || in_vars)
			idx_n = idx_q + 1'b1;

		deg_s = sign_of(REM_W'(deg_n));
		sum_s = sign_of(REM_W'(sum_n));
		rem_s = sign_of(rem_n);

		order = SGN_ZERO;
		unique case (cfg.order_mode)
			MODE_LEX:       order = lex_first_n;
			MODE_DEGLEX:    order = (deg_s != SGN_ZERO) ? deg_s : lex_first_n;
			MODE_DEGREVLEX: order = (deg_s != SGN_ZERO) ? deg_s : -all_last_n;
			MODE_BLOCK: begin
				if (sum_s != SGN_ZERO)
					order = sum_s;
				else if (low_last_n != SGN_ZERO)
					order = -low_last_n;
				else if (rem_s != SGN_ZERO)
					order = rem_s;
				else
					order = -high_last_n;
			end
			default: order = SGN_ZERO;
		endcase
	end

	assign res.valid = take & beat.last;
	assign res.order = order;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			deg_q       <= '0;
			sum_q       <= '0;
			rem_q       <= '0;
			lex_first_q <= SGN_ZERO;
			all_last_q  <= SGN_ZERO;
			low_last_q  <= SGN_ZERO;
			high_last_q <= SGN_ZERO;
		end else if (take) begin
			if (beat.last) begin
				idx_q       <= '0;
				deg_q       <= '0;
				sum_q       <= '0;
				rem_q       <= '0;
				lex_first_q <= SGN_ZERO;
				all_last_q  <= SGN_ZERO;
				low_last_q  <= SGN_ZERO;
				high_last_q <= SGN_ZERO;
			end else begin
				idx_q       <= idx_n;
				deg_q       <= deg_n;
				sum_q       <= sum_n;
				rem_q       <= rem_n;
				lex_first_q <= lex_first_n;
				all_last_q  <= all_last_n;
				low_last_q  <= low_last_n;
				high_last_q <= high_last_n;
			end
		end
	end

endmodule

>>> rtl/moc_out_stage.sv
// result register toward the master side
// depends on moc_pkg

module moc_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  moc_pkg::res_t               res,
	output logic                        out_free,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [moc_pkg::M_DATA_W-1:0] m_tdata
);
	import moc_pkg::*;

	logic valid_q;
	sgn_t order_q;

	assign out_free = ~valid_q | m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {{(M_DATA_W-2){1'b0}}, order_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid)
			order_q <= res.order;
	end

endmodule

>>> rtl/monomial_order_compare_core.sv
// tlast beat to m_tvalid: input, then result register, plus any output stall
// throughput: one element beat per cycle unless an output stall holds a tlast beat,
// one result per vector pair; rate set by the accumulator between the two registers
// reset: arst_n clears both valid bits, all running state and the config to zero
// top level of the monomial order comparator; depends on moc_pkg, moc_cfg,
// moc_in_stage, moc_accum and moc_out_stage

module monomial_order_compare_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [moc_pkg::S_DATA_W-1:0] s_tdata,  // exp_first, exp_second, zero pad
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [moc_pkg::M_DATA_W-1:0] m_tdata,  // order (signed), zero pad
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [moc_pkg::APB_AW-1:0]   paddr,
	input  logic [moc_pkg::APB_DW-1:0]   pwdata,
	output logic [moc_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	import moc_pkg::*;

	cfg_t  cfg;
	beat_t beat;
	res_t  res;
	logic  take;
	logic  out_free;

	moc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	moc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.out_free (out_free),
		.take     (take),
		.beat     (beat)
	);

	moc_accum u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.take   (take),
		.beat   (beat),
		.res    (res)
	);

	moc_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> rtl/moc_checker.sv
// port-level checks for the monomial order comparator, bound to the top level
// depends on moc_pkg

module moc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [moc_pkg::S_DATA_W-1:0] s_tdata,
	input logic                         s_tlast,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [moc_pkg::M_DATA_W-1:0] m_tdata,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [moc_pkg::APB_AW-1:0]   paddr,
	input logic [moc_pkg::APB_DW-1:0]   pwdata,
	input logic [moc_pkg::APB_DW-1:0]   prdata,
	input logic                         pready
);
	import moc_pkg::*;

	// offered element beat holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
		else $error("element beat changed before accept");

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed under stall");

	// order is one of 1, 0, -1
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'b10)
		else $error("illegal order code");

	// pad bits of the result stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_DATA_W-1:2] == '0)
		else $error("result pad bits set");

	// a mode write reads back masked to its width
	a_rdback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_ORDER_MODE
		&& !pwrite == 1'b0 |=> (paddr[2] != REG_ORDER_MODE)
		|| (prdata == APB_DW'($past(pwdata[MODE_W-1:0]))))
		else $error("order_mode readback mismatch");

endmodule

bind monomial_order_compare_core moc_checker u_chk (.*);
